// ===== hdl/polar_sector_classifier_assert.svh =====
// Assertion macros used by the polar sector classifier checker.
`ifndef POLAR_SECTOR_CLASSIFIER_ASSERT_SVH
`define POLAR_SECTOR_CLASSIFIER_ASSERT_SVH

// Checked only while the block is out of reset.
`define PSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("polar sector classifier check failed");

// Checked on every clock edge, reset included.
`define PSC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("polar sector classifier reset check failed");

`endif

// ===== hdl/psc_pkg.sv =====
// Shared types, constants and CORDIC helpers for the polar sector classifier.
`default_nettype none
package psc_pkg;

    localparam int COORD_BITS   = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int MAX_SECTORS  = 64;
    localparam int ANGLE_TOL    = 52;
    localparam int CORDIC_STEPS = 30;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int CX_BITS      = DIFF_BITS + 16 + 4;
    localparam int CNT_BITS     = 7;
    localparam int IDX_BITS     = 6;
    localparam int RAD_BITS     = COORD_BITS - 1;
    localparam int ADDR_BITS    = 5;

    localparam logic [2:0] REG_CENTER_X     = 3'd0;
    localparam logic [2:0] REG_CENTER_Y     = 3'd1;
    localparam logic [2:0] REG_DEAD_RADIUS  = 3'd2;
    localparam logic [2:0] REG_SECTOR_COUNT = 3'd3;
    localparam logic [2:0] REG_START_ANGLE  = 3'd4;

    typedef logic signed [CX_BITS-1:0]   t_cx;
    typedef logic signed [DIFF_BITS-1:0] t_diff;
    typedef logic [ANGLE_BITS-1:0]       t_angle;

    typedef struct packed {
        t_cx         x;
        t_cx         y;
        logic [31:0] acc;
    } t_cordic;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0:  v = 32'd536870912;
                1:  v = 32'd316933406;
                2:  v = 32'd167458907;
                3:  v = 32'd85004756;
                4:  v = 32'd42667331;
                5:  v = 32'd21354465;
                6:  v = 32'd10679838;
                7:  v = 32'd5340245;
                8:  v = 32'd2670163;
                9:  v = 32'd1335087;
                10: v = 32'd667544;
                11: v = 32'd333772;
                12: v = 32'd166886;
                13: v = 32'd83443;
                14: v = 32'd41722;
                15: v = 32'd20861;
                16: v = 32'd10430;
                17: v = 32'd5215;
                18: v = 32'd2608;
                19: v = 32'd1304;
                20: v = 32'd652;
                21: v = 32'd326;
                22: v = 32'd163;
                23: v = 32'd81;
                24: v = 32'd41;
                25: v = 32'd20;
                26: v = 32'd10;
                27: v = 32'd5;
                28: v = 32'd3;
                29: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

    function automatic t_cordic cordic_step(input t_cordic c, input int idx);
        t_cordic r;
        t_cx xs;
        t_cx ys;
        begin
            xs = c.x >>> idx;
            ys = c.y >>> idx;
            if (c.y > 0) begin
                r.x   = c.x + ys;
                r.y   = c.y - xs;
                r.acc = c.acc + atan_turn(idx);
            end else begin
                r.x   = c.x - ys;
                r.y   = c.y + xs;
                r.acc = c.acc - atan_turn(idx);
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/psc_if.sv =====
// Valid/ready channel interfaces for points and classification results.
`default_nettype none
interface psc_pt_if;
    import psc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface psc_res_if;
    import psc_pkg::*;
    logic                valid;
    logic                ready;
    logic                center_hit;
    logic                sector_hit;
    logic [IDX_BITS-1:0] sector_number;
    modport source (output valid, output center_hit, output sector_hit,
                    output sector_number, input ready);
    modport sink (input valid, input center_hit, input sector_hit,
                  input sector_number, output ready);
endinterface
`default_nettype wire

// ===== hdl/psc_cordic.sv =====
// Pipelined vectoring CORDIC that turns a center offset into a turn-unit angle.
`default_nettype none
module psc_cordic import psc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire t_diff       i_dx,
    input  wire t_diff       i_dy,
    input  wire logic        i_tag,
    output logic             o_vld,
    output logic [31:0]      o_acc,
    output logic             o_tag
);

    t_cordic r_st  [CORDIC_STAGES];
    logic    r_vld [CORDIC_STAGES];
    logic    r_tag [CORDIC_STAGES];
    t_cordic n_init;
    t_cx     ext_x;
    t_cx     ext_y;

    always_comb begin
        ext_x = t_cx'(i_dx) <<< 16;
        ext_y = t_cx'(i_dy) <<< 16;
        if (ext_x < 0) begin
            n_init.x   = -ext_x;
            n_init.y   = -ext_y;
            n_init.acc = 32'h8000_0000;
        end else begin
            n_init.x   = ext_x;
            n_init.y   = ext_y;
            n_init.acc = 32'h0;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        t_cordic n_st;
        always_comb begin
            n_st = (g == 0) ? n_init : r_st[(g == 0) ? 0 : g-1];
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                n_st = cordic_step(n_st, g*STEPS_PER_STAGE + k);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= (g == 0) ? i_vld : r_vld[(g == 0) ? 0 : g-1];
            end
            if (i_en) begin
                r_st[g]  <= n_st;
                r_tag[g] <= (g == 0) ? i_tag : r_tag[(g == 0) ? 0 : g-1];
            end
        end
    end

    assign o_vld = r_vld[CORDIC_STAGES-1];
    assign o_acc = r_st[CORDIC_STAGES-1].acc;
    assign o_tag = r_tag[CORDIC_STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/polar_sector_classifier.sv =====
// Top level of the polar sector classifier: config registers, pipeline and output skid.
// Pipeline: each accepted point passes 20 register stages (r1, r2, CORDIC, r4, r5, output).
// Throughput: one point per cycle while the skid is empty; the 15-stage CORDIC sets depth.
// The output stage holds one stalled result in a skid register while ready is low.
// Reset is synchronous and active low; it clears the valid bits and the config registers.
`default_nettype none
module polar_sector_classifier import psc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    psc_pt_if.sink                    i_pt,
    psc_res_if.source                 o_res,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    typedef struct packed {
        logic                center_hit;
        logic                sector_hit;
        logic [IDX_BITS-1:0] sector_number;
    } t_res;

    logic [COORD_BITS-1:0] r_center_x;
    logic [COORD_BITS-1:0] r_center_y;
    logic [RAD_BITS-1:0]   r_dead_radius;
    logic [CNT_BITS-1:0]   r_sector_count;
    t_angle                r_start_angle;

    logic                  en;
    logic                  wr;
    logic [CNT_BITS-1:0]   n_sat;

    logic                  r1_vld;
    t_diff                 r1_dx;
    t_diff                 r1_dy;
    logic                  r2_vld;
    t_diff                 r2_dx;
    t_diff                 r2_dy;
    logic [31:0]           r2_sqx;
    logic [31:0]           r2_sqy;
    logic [2*RAD_BITS-1:0] r2_rsq;
    logic                  n_center_hit;
    logic [COORD_BITS-1:0] ux;
    logic [COORD_BITS-1:0] uy;

    logic                  c_vld;
    logic [31:0]           c_acc;
    logic                  c_tag;
    logic [31:0]           acc_rnd;

    logic                  r4_vld;
    logic                  r4_tag;
    t_angle                r4_e;
    logic                  r5_vld;
    logic                  r5_tag;
    logic [23:0]           r5_p1;
    logic [23:0]           r5_p2;

    logic [23:0]           p1m;
    logic [IDX_BITS-1:0]   idx;
    logic [23:0]           bound;
    t_res                  n_res;
    t_res                  r_res;
    logic                  r_out_vld;
    t_res                  r_skid;
    logic                  r_skid_vld;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_dead_radius  <= '0;
            r_sector_count <= '0;
            r_start_angle  <= '0;
        end else if (wr) begin
            unique case (paddr[ADDR_BITS-1:2])
                REG_CENTER_X:     r_center_x     <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Y:     r_center_y     <= pwdata[COORD_BITS-1:0];
                REG_DEAD_RADIUS:  r_dead_radius  <= pwdata[RAD_BITS-1:0];
                REG_SECTOR_COUNT: r_sector_count <= pwdata[CNT_BITS-1:0];
                REG_START_ANGLE:  r_start_angle  <= pwdata[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_BITS-1:2])
            REG_CENTER_X:     prdata = {16'h0, r_center_x};
            REG_CENTER_Y:     prdata = {16'h0, r_center_y};
            REG_DEAD_RADIUS:  prdata = {17'h0, r_dead_radius};
            REG_SECTOR_COUNT: prdata = {25'h0, r_sector_count};
            REG_START_ANGLE:  prdata = {16'h0, r_start_angle};
            default:          prdata = 32'h0;
        endcase
    end

    assign n_sat = (r_sector_count > CNT_BITS'(MAX_SECTORS)) ?
                   CNT_BITS'(MAX_SECTORS) : r_sector_count;

    assign en         = !r_skid_vld;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_pt.valid;
            r2_vld <= r1_vld;
            r4_vld <= c_vld;
            r5_vld <= r4_vld;
        end
    end

    assign ux = r1_dx[DIFF_BITS-1] ? COORD_BITS'(-r1_dx) : COORD_BITS'(r1_dx);
    assign uy = r1_dy[DIFF_BITS-1] ? COORD_BITS'(-r1_dy) : COORD_BITS'(r1_dy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx  <= t_diff'(i_pt.point_x) - t_diff'($signed(r_center_x));
            r1_dy  <= t_diff'(i_pt.point_y) - t_diff'($signed(r_center_y));
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_sqx <= ux * ux;
            r2_sqy <= uy * uy;
            r2_rsq <= r_dead_radius * r_dead_radius;
        end
    end

    assign n_center_hit = ({1'b0, r2_sqx} + {1'b0, r2_sqy}) <= {3'b0, r2_rsq};

    psc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r2_vld),
        .i_dx    (r2_dx),
        .i_dy    (r2_dy),
        .i_tag   (n_center_hit),
        .o_vld   (c_vld),
        .o_acc   (c_acc),
        .o_tag   (c_tag)
    );

    assign acc_rnd = c_acc + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_tag <= c_tag;
            r4_e   <= acc_rnd[31:16] - r_start_angle + ANGLE_BITS'(ANGLE_TOL);
            r5_tag <= r4_tag;
            r5_p1  <= ({7'b0, r4_e} + 24'd1) * {17'b0, n_sat};
            r5_p2  <= ({7'b0, r4_e} + 24'(ANGLE_TOL)) * {17'b0, n_sat};
        end
    end

    assign p1m   = r5_p1 - 24'd1;
    assign idx   = p1m[ANGLE_BITS+IDX_BITS-1:ANGLE_BITS];
    assign bound = {1'b0, ({1'b0, idx} + 7'd1), 16'h0};

    always_comb begin
        n_res = '0;
        priority if (r5_tag) begin
            n_res.center_hit = 1'b1;
        end else if (n_sat == '0) begin
            n_res.sector_hit = 1'b0;
        end else if (n_sat == CNT_BITS'(1)) begin
            n_res.sector_hit = 1'b1;
        end else if (r5_p2 <= bound) begin
            n_res.sector_hit    = 1'b1;
            n_res.sector_number = idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (en) begin
                r_out_vld  <= r5_vld;
                r_skid_vld <= r_out_vld && !o_res.ready;
            end else if (o_res.ready) begin
                r_skid_vld <= 1'b0;
            end
        end
        if (en) begin
            r_res  <= n_res;
            r_skid <= r_res;
        end
    end

    assign o_res.valid         = r_skid_vld || r_out_vld;
    assign o_res.center_hit    = r_skid_vld ? r_skid.center_hit    : r_res.center_hit;
    assign o_res.sector_hit    = r_skid_vld ? r_skid.sector_hit    : r_res.sector_hit;
    assign o_res.sector_number = r_skid_vld ? r_skid.sector_number : r_res.sector_number;

endmodule
`default_nettype wire

// ===== hdl/psc_checker.sv =====
// Port-level assertion checker for the polar sector classifier and its bind.
`default_nettype none
`include "polar_sector_classifier_assert.svh"
module psc_checker import psc_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic                i_center_hit,
    input wire logic                i_sector_hit,
    input wire logic [IDX_BITS-1:0] i_sector_number
);

    `PSC_ASSERT(a_center_no_hit, i_out_valid && i_center_hit |-> !i_sector_hit)
    `PSC_ASSERT(a_miss_zero, i_out_valid && !i_sector_hit |-> i_sector_number == '0)
    `PSC_ASSERT(a_stall_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sector_number))
    `PSC_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !i_out_valid)

endmodule

bind polar_sector_classifier psc_checker u_psc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_center_hit    (o_res.center_hit),
    .i_sector_hit    (o_res.sector_hit),
    .i_sector_number (o_res.sector_number)
);
`default_nettype wire
